/* hw/rtl/ewx_pkg.sv */
// ewx_pkg: shared types, register indexes and widths for the encoder wrap extender.
// No dependencies; used by ewx_div, ewx_track and encoder_wrap_extender_core.
package ewx_pkg;

    localparam int COUNTER_BITS_DEF = 16;  // width of the external encoder counter
    localparam int TICKS_W          = 32;  // ticks_per_turn register width
    localparam int SAMPLE_W         = 16;  // counter_sample port width
    localparam int POS_W            = 32;  // position width
    localparam int CFG_DATA_W       = 32;  // widest register
    localparam int CFG_IDX_W        = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKS     = 1'b0,
        REG_USES_ZERO = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_READ = 1'b0,
        OP_ZERO = 1'b1
    } t_op;

endpackage

/* hw/rtl/ewx_div.sv */
// ewx_div: restoring divider, one quotient bit per cycle; the quotient register
// holds the counter period between runs. Depends on ewx_pkg.
module ewx_div #(
    parameter int NUM_W = ewx_pkg::TICKS_W,
    parameter int DEN_W = ewx_pkg::TICKS_W + 1 - ewx_pkg::COUNTER_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;   // dividend bits shift out, quotient bits shift in
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             take;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        take  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_num  <= NUM_W'(1);  // period reads as one before the first run
            r_rem  <= '0;
            r_den  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_num  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], take};
            r_rem <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;

endmodule

/* hw/rtl/ewx_track.sv */
// ewx_track: last sample and wrap counter state, wrap detection and position math.
// Depends on ewx_pkg.
module ewx_track #(
    parameter int COUNTER_BITS = ewx_pkg::COUNTER_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ewx_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [COUNTER_BITS-1:0]        i_period,
    input  logic [ewx_pkg::TICKS_W-COUNTER_BITS:0] i_wraps,
    output logic [ewx_pkg::POS_W-1:0]      o_position
);

    localparam int CB = COUNTER_BITS;
    localparam int WW = ewx_pkg::TICKS_W + 1 - CB;
    localparam int SW = (CB < ewx_pkg::SAMPLE_W) ? CB : ewx_pkg::SAMPLE_W;
    localparam int PW = WW + CB;

    logic [SW-1:0] r_last;
    logic [WW-1:0] r_wc;

    logic [SW-1:0] sample;
    logic [SW:0]   diff;
    logic          fall;
    logic [SW-1:0] mag;
    logic          jump;
    logic [WW:0]   wc_inc;
    logic [WW:0]   wc_inc_sub;
    logic [WW-1:0] wc_fwd;
    logic [WW-1:0] wc_bwd;
    logic [WW-1:0] n_wc;
    logic [PW-1:0] prod;

    always_comb begin
        sample     = i_sample[SW-1:0];
        diff       = {1'b0, sample} - {1'b0, r_last};
        fall       = diff[SW];
        mag        = fall ? SW'(-diff) : diff[SW-1:0];
        jump       = (CB'(mag) > (i_period >> 1)) && (i_wraps != '0);
        // forward step modulo wraps, one subtract only (stale counts allowed)
        wc_inc     = {1'b0, r_wc} + 1'b1;
        wc_inc_sub = wc_inc - {1'b0, i_wraps};
        wc_fwd     = (wc_inc >= {1'b0, i_wraps}) ? wc_inc_sub[WW-1:0] : wc_inc[WW-1:0];
        wc_bwd     = (r_wc == '0) ? (i_wraps - 1'b1) : (r_wc - 1'b1);
        n_wc       = jump ? (fall ? wc_fwd : wc_bwd) : r_wc;
        prod       = PW'(n_wc) * PW'(i_period);
        o_position = prod[ewx_pkg::POS_W-1:0] + ewx_pkg::POS_W'(sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_wc   <= '0;
        end else if (i_step) begin
            r_last <= sample;
            r_wc   <= n_wc;
        end
    end

endmodule

/* hw/rtl/encoder_wrap_extender_core.sv */
// encoder_wrap_extender_core: top level of the encoder wrap extender.
// Depends on ewx_pkg, ewx_div and ewx_track.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------
//  input   | in        | i_in_valid / o_in_ready | i_op, i_counter_sample
//  output  | out       | o_out_valid/ i_out_ready| o_position, o_zero_seen
//  config  | in        | i_cfg_we (no wait)      | i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while the divider is idle and results
// drain. A read transaction waits in the input register, then its result lands
// in the output register. A zero mark leaves the input register without a result.
// Writing ticks_per_turn starts the period divider: o_in_ready stays low while
// it runs (one quotient bit per cycle). Reset is synchronous, active low.
// The output register stalls the input register only when a read result
// still waits; zero marks pass a stalled output.
module encoder_wrap_extender_core #(
    parameter int COUNTER_BITS = ewx_pkg::COUNTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config port
    input  logic                             i_cfg_we,
    input  logic [ewx_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ewx_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [ewx_pkg::SAMPLE_W-1:0]     i_counter_sample,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ewx_pkg::POS_W-1:0]        o_position,
    output logic                             o_zero_seen
);

    localparam int CB = COUNTER_BITS;
    localparam int TW = ewx_pkg::TICKS_W;
    localparam int WW = TW + 1 - CB;   // wraps per turn reach 2^(32-CB)

    // configuration and derived turn geometry
    logic          r_uses_zero;
    logic          r_has_zero;
    logic [WW-1:0] r_wraps;

    logic [TW-1:0] ticks_eff;    // zero ticks counts as one
    logic [TW:0]   wraps_full;
    logic          ticks_wr;
    logic          uses_wr;
    logic          div_busy;
    logic [TW-1:0] div_quot;
    logic [CB-1:0] period;

    // input register
    logic                         r_a_valid;
    logic                         r_a_op;
    logic [ewx_pkg::SAMPLE_W-1:0] r_a_sample;

    // output register
    logic                         r_out_valid;
    logic [ewx_pkg::POS_W-1:0]    r_out_pos;
    logic                         r_out_zs;

    logic                         a_adv;
    logic                         a_read;
    logic                         step;
    logic [ewx_pkg::POS_W-1:0]    trk_pos;

    always_comb begin
        ticks_wr   = i_cfg_we && (i_cfg_idx == ewx_pkg::REG_TICKS);
        uses_wr    = i_cfg_we && (i_cfg_idx == ewx_pkg::REG_USES_ZERO);
        ticks_eff  = (i_cfg_data[TW-1:0] == '0) ? TW'(1) : i_cfg_data[TW-1:0];
        wraps_full = ({1'b0, ticks_eff} >> CB) + 1'b1;
        period     = div_quot[CB-1:0];
    end

    // input register moves on when its result has room; zero marks never wait
    always_comb begin
        a_read     = r_a_valid && (r_a_op == ewx_pkg::OP_READ);
        a_adv      = r_a_valid && (!a_read || !r_out_valid || i_out_ready);
        o_in_ready = !div_busy && (!r_a_valid || a_adv);
        step       = a_adv && a_read && r_has_zero;
    end

    ewx_div #(
        .NUM_W (TW),
        .DEN_W (WW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ticks_wr),
        .i_num   (ticks_eff),
        .i_den   (wraps_full[WW-1:0]),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    ewx_track #(
        .COUNTER_BITS (CB)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_sample   (r_a_sample),
        .i_period   (period),
        .i_wraps    (r_wraps),
        .o_position (trk_pos)
    );

    // config registers and zero-seen flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uses_zero <= 1'b0;
            r_has_zero  <= 1'b1;
            r_wraps     <= '0;
        end else begin
            if (ticks_wr) begin
                r_wraps    <= wraps_full[WW-1:0];
                r_has_zero <= !r_uses_zero;
            end else if (uses_wr) begin
                r_uses_zero <= i_cfg_data[0];
                r_has_zero  <= !i_cfg_data[0];
            end else if (a_adv && (r_a_op == ewx_pkg::OP_ZERO)) begin
                r_has_zero <= 1'b1;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_op     <= i_op;
            r_a_sample <= i_counter_sample;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (a_adv && a_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv && a_read) begin
            r_out_pos <= r_has_zero ? trk_pos : '0;
            r_out_zs  <= r_has_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_zero_seen = r_out_zs;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_magic_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_zero_seen) |-> (o_position == '0))
        else $error("position not zero while zero mark missing");

    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> !o_in_ready)
        else $error("input taken while period divider runs");

    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ticks_wr |=> div_busy)
        else $error("ticks write did not start the divider");

    a_zero_mark_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_adv && (r_a_op == ewx_pkg::OP_ZERO) && !i_cfg_we) |=> r_has_zero)
        else $error("zero mark did not set the zero-seen flag");

endmodule

/* tb/ewx_checker.sv */
`timescale 1ns / 1ps
// ewx_checker: watches the config port and both channels of the encoder wrap
// extender, predicts each read result and compares it. Depends on ewx_pkg.
module ewx_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ewx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ewx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_op,
    input  logic [ewx_pkg::SAMPLE_W-1:0]   i_counter_sample,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [ewx_pkg::POS_W-1:0]      i_position,
    input  logic                           i_zero_seen,
    output int                             o_pending,
    output int                             o_fail_count
);
    import ewx_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             zero_seen;
    } t_turn_pos;

    t_turn_pos           pos_q[$];   // predicted positions, oldest first

    logic                uses_zero;
    logic [16:0]         wraps;
    logic [15:0]         period;
    logic [SAMPLE_W-1:0] last_smp;
    logic [16:0]         wrap_cnt;
    logic                zero_ok;
    int                  fails = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fails++;
    endtask

    task automatic set_turn(input logic [TICKS_W-1:0] tpt);
        longint unsigned t;
        t      = (tpt == 0) ? 64'd1 : 64'(tpt);
        wraps  = 17'((t >> COUNTER_BITS_DEF) + 1);
        period = 16'(t / ((t >> COUNTER_BITS_DEF) + 1));
    endtask

    task automatic track_read(input logic [SAMPLE_W-1:0] smp, output t_turn_pos res);
        longint          cur;
        longint          prev;
        longint          jump;
        longint unsigned sum;
        if (!zero_ok) begin
            // index mark still missing: magic zero, state untouched
            res.position  = '0;
            res.zero_seen = 1'b0;
        end else begin
            cur  = smp;
            prev = last_smp;
            jump = cur - prev;
            if (((jump < 0) ? -jump : jump) > longint'(period >> 1) && wraps != 0) begin
                if (jump < 0) begin
                    wrap_cnt = wrap_cnt + 1'b1;
                    if (wrap_cnt >= wraps)
                        wrap_cnt = wrap_cnt - wraps;
                end else if (wrap_cnt == 0) begin
                    wrap_cnt = wraps - 1'b1;
                end else begin
                    wrap_cnt = wrap_cnt - 1'b1;
                end
            end
            sum           = 64'(wrap_cnt) * 64'(period) + 64'(smp);
            res.position  = sum[POS_W-1:0];
            res.zero_seen = 1'b1;
            last_smp      = smp;
        end
    endtask

    always @(posedge i_clk) begin
        t_turn_pos want;
        t_turn_pos got;
        if (!i_rst_n) begin
            uses_zero = 1'b0;
            wraps     = '0;
            period    = 16'd1;
            last_smp  = '0;
            wrap_cnt  = '0;
            zero_ok   = 1'b1;
            pos_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_TICKS) begin
                    set_turn(i_cfg_data);
                end else begin
                    uses_zero = i_cfg_data[0];
                end
                zero_ok = !uses_zero;
            end
            // results first: a transaction accepted at this edge cannot answer yet
            if (i_out_valid && i_out_ready) begin
                got.position  = i_position;
                got.zero_seen = i_zero_seen;
                if (pos_q.size() == 0) begin
                    report_mismatch($sformatf("result pos=%0h zero_seen=%0b with none pending",
                                              got.position, got.zero_seen));
                end else begin
                    want = pos_q.pop_front();
                    if (got.position !== want.position)
                        report_mismatch($sformatf("position expected %0h got %0h",
                                                  want.position, got.position));
                    if (got.zero_seen !== want.zero_seen)
                        report_mismatch($sformatf("zero_seen expected %0b got %0b",
                                                  want.zero_seen, got.zero_seen));
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_op'(i_op) == OP_ZERO) begin
                    zero_ok = 1'b1;
                end else begin
                    track_read(i_counter_sample, want);
                    pos_q.push_back(want);
                end
            end
        end
        o_pending    <= pos_q.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/encoder_wrap_extender_core_tb.sv */
`timescale 1ns / 1ps
// encoder_wrap_extender_core_tb: stimulus, flow control and verdict for the
// encoder wrap extender. Depends on ewx_pkg, encoder_wrap_extender_core, ewx_checker.
module encoder_wrap_extender_core_tb;
    import ewx_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 6;    // a zero mark leaves the pipe in the cycle after its accept
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 160;  // ~1600 random transactions in total
    localparam int LONG_HOLD       = 120;  // receiver back-pressure stretch, cycles
    localparam int RUN_LIMIT_NS    = 3_000_000;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  in_op     = OP_READ;
    logic [SAMPLE_W-1:0]   in_sample = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POS_W-1:0]      position;
    logic                  zero_seen;

    int                    pending;
    int                    fail_count;
    bit                    long_hold_req = 1'b0;  // sender asks the receiver to stall

    encoder_wrap_extender_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_op             (in_op),
        .i_counter_sample (in_sample),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_position       (position),
        .o_zero_seen      (zero_seen)
    );

    ewx_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_op             (in_op),
        .i_counter_sample (in_sample),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_position       (position),
        .i_zero_seen      (zero_seen),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the pipe hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: ready pattern switches between random modes; on request it holds
    // ready low for the LONG_HOLD stretch so the block backs up.
    initial begin : rx_side
        int mode;
        int mode_left;
        int hold;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                for (hold = 1; hold < LONG_HOLD; hold++)
                    @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;                       // no stalls
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0); // mostly stalled
                    default: out_ready <= ~out_ready;                 // alternating
                endcase
            end
        end
    end

    // Offer one transaction and return at the edge where it is accepted.
    task automatic send_txn(input t_op op, input logic [SAMPLE_W-1:0] smp);
        in_valid  <= 1'b1;
        in_op     <= op;
        in_sample <= smp;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted result has come out, then
    // let any zero mark still in flight leave the pipe.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stim
        logic [TICKS_W-1:0] ticks;
        logic               uses;
        longint             span;
        longint             enc;
        longint             mag;
        int                 burst_left;
        int                 gap;
        int                 pick;
        int                 p;
        int                 i;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // No ticks written yet: wrap counter frozen, position is the bare sample.
        send_txn(OP_READ, 16'h0000);
        send_txn(OP_READ, 16'hFFFF);
        send_txn(OP_READ, 16'h8000);
        send_txn(OP_READ, 16'h0001);

        // Zero ticks counts as one: one wrap per turn, period 1.
        wait_drained();
        write_reg(REG_USES_ZERO, '0);
        write_reg(REG_TICKS, '0);
        send_txn(OP_READ, 16'h0000);
        send_txn(OP_READ, 16'hFFFF);
        send_txn(OP_READ, 16'h0007);

        // Full 32-bit turn with the index mark required: magic zero first, then
        // wraps forward and back, including a step back from wrap 0. Ends on the
        // top wrap so the next turn setting starts with a stale count.
        wait_drained();
        write_reg(REG_USES_ZERO, 32'd1);
        write_reg(REG_TICKS, 32'hFFFF_FFFF);
        send_txn(OP_READ, 16'd1234);
        send_txn(OP_ZERO, 16'd0);
        send_txn(OP_READ, 16'd0);
        send_txn(OP_READ, 16'd40000);
        send_txn(OP_READ, 16'd65534);
        send_txn(OP_READ, 16'd10);
        send_txn(OP_READ, 16'd60000);
        send_txn(OP_READ, 16'd65535);

        // New ticks while running: stale wrap count above the new range.
        wait_drained();
        write_reg(REG_TICKS, 32'd65536);
        send_txn(OP_ZERO, 16'd0);
        send_txn(OP_READ, 16'd32767);
        send_txn(OP_READ, 16'd0);
        send_txn(OP_READ, 16'd20000);

        // Dropping the mark requirement re-arms the zero flag.
        wait_drained();
        write_reg(REG_USES_ZERO, '0);
        send_txn(OP_READ, 16'hFFFF);
        send_txn(OP_READ, 16'h0000);

        // ---- random part: one setting per phase ----
        enc = 0;
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       ticks = '0;
                1:       ticks = 32'd1;
                2:       ticks = 32'hFFFF_FFFF;
                3:       ticks = 32'd65535;
                4:       ticks = 32'd65536;
                5:       ticks = 32'd131071;
                default: ticks = ($urandom_range(0, 1) == 1) ? 32'($urandom_range(2, 200000))
                                                              : 32'($urandom());
            endcase
            uses = (p % 3 == 1);
            wait_drained();
            write_reg(REG_USES_ZERO, 32'(uses));
            write_reg(REG_TICKS, ticks);

            // external counter runs 0 .. span-1
            span = (ticks == 0) ? 1 : longint'(ticks);
            span = span / ((span >> COUNTER_BITS_DEF) + 1);
            enc  = enc % span;

            if (uses) begin
                repeat ($urandom_range(1, 3)) send_txn(OP_READ, 16'(enc));
                send_txn(OP_ZERO, 16'($urandom()));
                enc = 0;
            end

            burst_left = 0;
            gap        = 0;
            if (p == 0) begin
                // back-to-back burst into a stalled receiver
                long_hold_req = 1'b1;
                burst_left    = 60;
            end

            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 3 && i == ITEMS_PER_PHASE / 2)
                    wait_drained();  // sender pause with nothing outstanding
                if (burst_left == 0) begin
                    idle_for(gap);
                    burst_left = $urandom_range(1, 24);
                    gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 5);
                end
                burst_left--;

                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    // index mark: external counter is cleared
                    send_txn(OP_ZERO, 16'($urandom()));
                    enc = 0;
                end else if (pick < 13) begin
                    send_txn(OP_READ, 16'($urandom()));   // noise sample
                end else begin
                    if (pick < 30) begin
                        // probe the half-period threshold
                        mag = span / 2 + longint'($urandom_range(0, 2)) - 1;
                        if (mag < 0)
                            mag = 0;
                    end else begin
                        mag = longint'($urandom_range(0, 32'(span / 3)));
                    end
                    if ($urandom_range(0, 1) == 1)
                        mag = -mag;
                    enc = ((enc + mag) % span + span) % span;
                    send_txn(OP_READ, 16'(enc));
                end
            end
        end

        wait_drained();
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ewx_pkg.sv
hw/rtl/ewx_div.sv
hw/rtl/ewx_track.sv
hw/rtl/encoder_wrap_extender_core.sv
tb/ewx_checker.sv
tb/encoder_wrap_extender_core_tb.sv
